@@ rtl/nst_pkg.sv @@
// Package for the name to sector table: operation and status codes, the
// token that walks the cell chain, the commit command and name normalization.
// Depends on nothing; every other file imports it.
package nst_pkg;

  // Width of a stored name: nine bytes.
  localparam int unsigned NameSlots = 9;
  localparam int unsigned NameW     = 8 * NameSlots;
  localparam int unsigned SectorW   = 10;

  typedef logic [NameW-1:0]   name_t;
  typedef logic [SectorW-1:0] sector_t;

  // Request operation codes. The fourth code leaves the table unchanged and reports not found.
  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic    vld;     // token present at this point of the chain
    logic    hit;     // some earlier cell matched the name
    logic    free;    // some earlier cell is empty
    sector_t sector;  // sector of the first matching cell
  } tok_t;

  // Commit command broadcast to all cells after a search.
  typedef struct packed {
    logic add;     // first free cell takes the request name and sector
    logic remove;  // first matching cell drops its valid mark
  } cmd_t;

  // Treat the name as a string: bytes from the first zero byte on, and bytes
  // at or above the configured length, read as zero.
  function automatic name_t nst_normalize(logic [63:0] head, logic [7:0] tail,
                                          int unsigned limit);
    name_t      raw;
    name_t      res;
    logic       ended;
    logic [7:0] b;
    raw   = {tail, head};
    res   = '0;
    ended = 1'b0;
    for (int unsigned i = 0; i < NameSlots; i++) begin
      b = raw[8*i +: 8];
      if (i >= limit || b == 8'd0) begin
        ended = 1'b1;
      end
      res[8*i +: 8] = ended ? 8'd0 : b;
    end
    return res;
  endfunction

endpackage

@@ rtl/name_to_sector_table.sv @@
// Name to sector table: a small associative table of short names and their
// sector numbers, built as a chain of slot cells. Depends on nst_pkg and nst_cell.
//
// Input channel (in_valid_i / in_stall_o) carries one request per beat:
// operation (find, add, remove), a name of up to NAME_BYTES bytes split in
// name_head_i and name_tail_i, and the sector to store on an add.
// Output channel (out_valid_o / out_stall_i) returns one result beat per
// request: success, status and the found sector.
//
// A token walks the ENTRIES cells one per cycle, so the first match and the
// first free slot are settled at the chain's end; a commit cycle then writes
// or clears the chosen cell and loads the output register. A new request is
// taken only after the commit of the one before: in_stall_o is high from a
// request beat until its commit.
//
// Reset clears all valid marks, so the table starts empty. While the
// receiver stalls, the result holds in the output register; the next
// request may still be taken and searched, and its commit waits until the
// output register is free.
module name_to_sector_table
  import nst_pkg::*;
#(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned NAME_BYTES = 9
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [1:0]   operation_i,
  input  logic [63:0]  name_head_i,
  input  logic [7:0]   name_tail_i,
  input  logic [9:0]   sector_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic         success_o,
  output logic [1:0]   status_o,
  output logic [9:0]   found_sector_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_COMMIT
  } state_e;

  state_e  state_q;
  logic    launch_q;
  logic    in_acc;
  logic    commit;
  logic    [1:0] req_op_q;
  name_t   req_name_q;
  sector_t req_sector_q;
  logic    res_hit_q, res_free_q;
  sector_t res_sector_q;
  cmd_t    cmd;
  tok_t    chain [ENTRIES+1];

  logic    out_valid_q;
  logic    success_q;
  logic    [1:0] status_q;
  sector_t found_sector_q;
  logic    success_d;
  logic    [1:0] status_d;
  sector_t found_sector_d;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign commit     = (state_q == S_COMMIT) && (!out_valid_q || !out_stall_i);

  // Request register, name normalized on the way in.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_op_q     <= operation_i;
      req_name_q   <= nst_normalize(name_head_i, name_tail_i, NAME_BYTES);
      req_sector_q <= sector_i;
    end
  end

  // Token entering the first cell: no hit, no free slot, no sector yet.
  assign chain[0] = {launch_q, 1'b0, 1'b0, {SectorW{1'b0}}};

  // The chain of slot cells.
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    nst_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .tok_i        (chain[g]),
      .tok_o        (chain[g+1]),
      .req_name_i   (req_name_q),
      .req_sector_i (req_sector_q),
      .cmd_i        (cmd)
    );
  end

  // Search outcome captured at the end of the chain.
  always_ff @(posedge clk_i) begin
    if (chain[ENTRIES].vld) begin
      res_hit_q    <= chain[ENTRIES].hit;
      res_free_q   <= chain[ENTRIES].free;
      res_sector_q <= chain[ENTRIES].sector;
    end
  end

  // Decide the result and the table update.
  always_comb begin
    success_d      = 1'b0;
    status_d       = ST_NOT_FOUND;
    found_sector_d = '0;
    cmd            = '0;
    unique case (req_op_q)
      OP_FIND: begin
        if (res_hit_q) begin
          success_d      = 1'b1;
          status_d       = ST_OK;
          found_sector_d = res_sector_q;
        end
      end
      OP_ADD: begin
        if (res_hit_q) begin
          status_d = ST_DUPLICATE;
        end else if (!res_free_q) begin
          status_d = ST_FULL;
        end else begin
          success_d = 1'b1;
          status_d  = ST_OK;
          cmd.add   = commit;
        end
      end
      OP_REMOVE: begin
        if (res_hit_q) begin
          success_d  = 1'b1;
          status_d   = ST_OK;
          cmd.remove = commit;
        end
      end
      default: begin
        success_d = 1'b0;
      end
    endcase
  end

  // Sequencer and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      launch_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      launch_q <= in_acc;
      // A new result takes the register; otherwise a taken beat leaves it.
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (chain[ENTRIES].vld) begin
            state_q <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (commit) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (commit) begin
      success_q      <= success_d;
      status_q       <= status_d;
      found_sector_q <= found_sector_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign success_o      = success_q;
  assign status_o       = status_q;
  assign found_sector_o = found_sector_q;

endmodule

@@ rtl/nst_cell.sv @@
// One table slot of the name to sector table: valid mark, name and sector,
// plus the stage of the search chain that passes the token on.
// Depends on nst_pkg.
module nst_cell
  import nst_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  tok_t    tok_i,
  output tok_t    tok_o,
  input  name_t   req_name_i,
  input  sector_t req_sector_i,
  input  cmd_t    cmd_i
);

  logic    valid_q, valid_d;
  name_t   name_q;
  sector_t sector_q;
  logic    first_hit_q, first_free_q;
  tok_t    tok_q, tok_d;
  logic    match;
  logic    my_hit, my_free;

  // Local compare and the priority against the cells before this one.
  assign match   = valid_q && (name_q == req_name_i);
  assign my_hit  = match && !tok_i.hit;
  assign my_free = !valid_q && !tok_i.free;

  always_comb begin
    tok_d.vld    = tok_i.vld;
    tok_d.hit    = tok_i.hit | match;
    tok_d.free   = tok_i.free | !valid_q;
    tok_d.sector = my_hit ? sector_q : tok_i.sector;
  end

  // The valid mark changes only on a commit aimed at this cell.
  always_comb begin
    valid_d = valid_q;
    if (cmd_i.add && first_free_q) begin
      valid_d = 1'b1;
    end else if (cmd_i.remove && first_hit_q) begin
      valid_d = 1'b0;
    end
  end

  // Control state: valid mark, role flags of the last search, token stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      first_hit_q  <= 1'b0;
      first_free_q <= 1'b0;
      tok_q        <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
      if (tok_i.vld) begin
        first_hit_q  <= my_hit;
        first_free_q <= my_free;
      end
    end
  end

  // Entry contents are written by an add that picked this cell.
  always_ff @(posedge clk_i) begin
    if (cmd_i.add && first_free_q) begin
      name_q   <= req_name_i;
      sector_q <= req_sector_i;
    end
  end

  assign tok_o = tok_q;

endmodule

@@ rtl/nst_assert.sv @@
// Port-level assertions for the name to sector table, bound to the top level.
// Depends on nst_pkg and name_to_sector_table.
module nst_assert
  import nst_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       success_o,
  input logic [1:0] status_o,
  input logic [9:0] found_sector_o
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(success_o) && $stable(found_sector_o))
    else $error("stalled result beat changed");

  // Success and an ok status go together.
  a_success_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (success_o == (status_o == ST_OK)))
    else $error("success disagrees with status");

  // A failed request reports no sector.
  a_sector_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (found_sector_o == '0))
    else $error("sector reported on failure");

  // After a request beat the block is busy with it.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while one is in flight");

endmodule

bind name_to_sector_table nst_assert u_nst_assert (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .success_o      (success_o),
  .status_o       (status_o),
  .found_sector_o (found_sector_o)
);
